@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL that checks itself.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is asserted
`define RLP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define RLP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/rlp_pkg.sv @@
// ----------------------------------------------------------------------------
// rlp_pkg
// Types and constants of the RLP stream flattener.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rlp_pkg;

  // parser phase
  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_DRAIN   = 2'd3
  } phase_t;

  // error codes on the result channel
  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_TRUNC = 2'd1,
    ERR_ITEMS = 2'd2,
    ERR_LEN   = 2'd3
  } err_t;

  // header byte boundaries
  localparam logic [7:0] BYTE_SINGLE_MAX = 8'h7f;
  localparam logic [7:0] STR_EMPTY       = 8'h80;
  localparam logic [7:0] STR_SHORT_MAX   = 8'hb7;
  localparam logic [7:0] STR_LONG_MAX    = 8'hbf;
  localparam logic [7:0] LIST_SHORT_MAX  = 8'hf7;

  // largest gathered length that can still take one more length byte
  localparam logic [31:0] LEN_SHIFT_MAX = 32'h00ff_ffff;

  // input item
  typedef struct packed {
    logic [7:0] in_byte;
    logic       seq_last;
  } rlp_in_t;

  // result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic [6:0] item_index;
    logic       item_end;
    logic       empty_item;
    logic       seq_end;
    logic [1:0] error_code;
  } rlp_out_t;

  // parser state
  typedef struct packed {
    phase_t      phase;
    logic [3:0]  length_bytes_left;
    logic        collecting_list_length;
    logic [31:0] payload_left;
    logic [7:0]  item_count;
  } rlp_state_t;

  localparam rlp_state_t STATE_RESET = '{
    phase:                  PH_HEADER,
    length_bytes_left:      4'd0,
    collecting_list_length: 1'b0,
    payload_left:           32'd0,
    item_count:             8'd0
  };

endpackage

@@ rtl/core/rlp_if.sv @@
// ----------------------------------------------------------------------------
// rlp_if
// Valid/ready channels for raw bytes in and flattened string bytes out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// raw byte channel
interface rlp_in_if;
  logic             valid;
  logic             ready;
  rlp_pkg::rlp_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// result channel
interface rlp_out_if;
  logic              valid;
  logic              ready;
  rlp_pkg::rlp_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/rlp_step.sv @@
// ----------------------------------------------------------------------------
// rlp_step
// One-byte parser step: next state and an optional result for one item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rlp_step (
  input  rlp_pkg::rlp_state_t cur,
  input  rlp_pkg::rlp_in_t    in_item,
  input  logic                items_full,
  output rlp_pkg::rlp_state_t nxt,
  output logic                res_vld,
  output rlp_pkg::rlp_out_t   res
);

  logic [7:0]  b;
  logic        last;
  logic [31:0] len_shift;
  logic [3:0]  len_dec;
  logic [7:0]  count_inc;

  assign b         = in_item.in_byte;
  assign last      = in_item.seq_last;
  assign len_shift = {cur.payload_left[23:0], b};
  assign len_dec   = (cur.length_bytes_left != 4'd0) ? 4'(cur.length_bytes_left - 4'd1) : 4'd0;
  assign count_inc = 8'(cur.item_count + 8'd1);

  // per-phase decision
  always_comb begin
    nxt            = cur;
    res_vld        = 1'b0;
    res.out_byte   = 8'd0;
    res.item_index = cur.item_count[6:0];
    res.item_end   = 1'b0;
    res.empty_item = 1'b0;
    res.seq_end    = last;
    res.error_code = rlp_pkg::ERR_NONE;

    unique case (cur.phase)
      rlp_pkg::PH_HEADER: begin
        if (b <= rlp_pkg::STR_LONG_MAX && items_full) begin
          res_vld        = 1'b1;
          res.error_code = rlp_pkg::ERR_ITEMS;
          nxt.phase      = rlp_pkg::PH_DRAIN;
        end else if (b <= rlp_pkg::BYTE_SINGLE_MAX) begin
          // single byte is its own item
          res_vld        = 1'b1;
          res.out_byte   = b;
          res.item_end   = 1'b1;
          nxt.item_count = count_inc;
        end else if (b == rlp_pkg::STR_EMPTY) begin
          res_vld        = 1'b1;
          res.item_end   = 1'b1;
          res.empty_item = 1'b1;
          nxt.item_count = count_inc;
        end else if (b <= rlp_pkg::STR_SHORT_MAX) begin
          if (last) begin
            res_vld        = 1'b1;
            res.error_code = rlp_pkg::ERR_TRUNC;
            nxt.phase      = rlp_pkg::PH_DRAIN;
          end else begin
            nxt.payload_left = {24'd0, 8'(b - rlp_pkg::STR_EMPTY)};
            nxt.phase        = rlp_pkg::PH_PAYLOAD;
          end
        end else if (b <= rlp_pkg::STR_LONG_MAX || b > rlp_pkg::LIST_SHORT_MAX) begin
          // long form: length bytes follow
          if (last) begin
            res_vld        = 1'b1;
            res.error_code = rlp_pkg::ERR_TRUNC;
            nxt.phase      = rlp_pkg::PH_DRAIN;
          end else begin
            nxt.collecting_list_length = (b > rlp_pkg::LIST_SHORT_MAX);
            nxt.length_bytes_left      = (b > rlp_pkg::LIST_SHORT_MAX) ?
                                         4'(b - rlp_pkg::LIST_SHORT_MAX) :
                                         4'(b - rlp_pkg::STR_SHORT_MAX);
            nxt.payload_left           = 32'd0;
            nxt.phase                  = rlp_pkg::PH_LENGTH;
          end
        end
        // short list header: consumed
      end

      rlp_pkg::PH_LENGTH: begin
        if (cur.payload_left > rlp_pkg::LEN_SHIFT_MAX) begin
          res_vld        = 1'b1;
          res.error_code = rlp_pkg::ERR_LEN;
          nxt.phase      = rlp_pkg::PH_DRAIN;
        end else begin
          nxt.payload_left      = len_shift;
          nxt.length_bytes_left = len_dec;
          if (len_dec != 4'd0) begin
            if (last) begin
              res_vld        = 1'b1;
              res.error_code = rlp_pkg::ERR_TRUNC;
              nxt.phase      = rlp_pkg::PH_DRAIN;
            end
          end else if (cur.collecting_list_length) begin
            nxt.collecting_list_length = 1'b0;
            nxt.payload_left           = 32'd0;
            nxt.phase                  = rlp_pkg::PH_HEADER;
          end else if (len_shift == 32'd0) begin
            // long form of zero length is an empty string
            res_vld        = 1'b1;
            res.item_end   = 1'b1;
            res.empty_item = 1'b1;
            nxt.item_count = count_inc;
            nxt.phase      = rlp_pkg::PH_HEADER;
          end else if (last) begin
            res_vld        = 1'b1;
            res.error_code = rlp_pkg::ERR_TRUNC;
            nxt.phase      = rlp_pkg::PH_DRAIN;
          end else begin
            nxt.phase = rlp_pkg::PH_PAYLOAD;
          end
        end
      end

      rlp_pkg::PH_PAYLOAD: begin
        if (cur.payload_left <= 32'd1) begin
          res_vld          = 1'b1;
          res.out_byte     = b;
          res.item_end     = 1'b1;
          nxt.item_count   = count_inc;
          nxt.payload_left = 32'd0;
          nxt.phase        = rlp_pkg::PH_HEADER;
        end else if (last) begin
          res_vld        = 1'b1;
          res.error_code = rlp_pkg::ERR_TRUNC;
          nxt.phase      = rlp_pkg::PH_DRAIN;
        end else begin
          res_vld          = 1'b1;
          res.out_byte     = b;
          nxt.payload_left = 32'(cur.payload_left - 32'd1);
        end
      end

      rlp_pkg::PH_DRAIN: begin
        // drop bytes until the end of the sequence
      end

      default: begin
      end
    endcase

    // every sequence starts from a clean state
    if (last) begin
      nxt = rlp_pkg::STATE_RESET;
    end
  end

endmodule

@@ rtl/core/rlp_stream_flattener.sv @@
// ----------------------------------------------------------------------------
// rlp_stream_flattener: flattens an RLP byte stream into string payload bytes
// path: a taken byte is registered in in_r, then its result in out_r, which drives out_if
// throughput: one byte per cycle while out_if is not stalled, set by the single parser step per byte
// reset: synchronous active-low rst_n clears both valid stages and the parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module rlp_stream_flattener #(
  parameter int unsigned MAX_ITEMS = 128
) (
  input  logic            clk,
  input  logic            rst_n,
  rlp_in_if.sink          in_if,
  rlp_out_if.source       out_if
);

  rlp_pkg::rlp_in_t    in_r;
  logic                in_vld_r;
  rlp_pkg::rlp_state_t state_r;
  rlp_pkg::rlp_state_t state_nxt;
  rlp_pkg::rlp_out_t   out_r;
  logic                out_vld_r;
  rlp_pkg::rlp_out_t   res;
  logic                res_vld;
  logic                adv;
  logic                items_full;

  // handshake: the input stage moves when the result register is free
  assign adv          = in_vld_r && (!out_vld_r || out_if.ready);
  assign in_if.ready  = !in_vld_r || adv;
  assign out_if.valid = out_vld_r;
  assign out_if.data  = out_r;
  assign items_full   = (state_r.item_count >= 8'(MAX_ITEMS));

  // parser step
  rlp_step u_step (
    .cur        (state_r),
    .in_item    (in_r),
    .items_full (items_full),
    .nxt        (state_nxt),
    .res_vld    (res_vld),
    .res        (res)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      state_r   <= rlp_pkg::STATE_RESET;
    end else begin
      if (in_if.valid && in_if.ready) begin
        in_vld_r <= 1'b1;
      end else if (adv) begin
        in_vld_r <= 1'b0;
      end
      if (adv) begin
        out_vld_r <= res_vld;
        state_r   <= state_nxt;
      end else if (out_if.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      in_r <= in_if.data;
    end
    if (adv && res_vld) begin
      out_r <= res;
    end
  end

  // checks
  `RLP_ASSERT(a_err_clean,
    out_vld_r && out_r.error_code != rlp_pkg::ERR_NONE |->
      out_r.out_byte == 8'd0 && !out_r.item_end && !out_r.empty_item,
    "error item carries data")
  `RLP_ASSERT(a_empty_ends,
    out_vld_r && out_r.empty_item |-> out_r.item_end && out_r.out_byte == 8'd0,
    "empty item not closed")
  `RLP_ASSERT(a_seq_restart,
    adv && in_r.seq_last |=> state_r.phase == rlp_pkg::PH_HEADER &&
      state_r.item_count == 8'd0 && state_r.payload_left == 32'd0,
    "state not cleared after sequence end")
  `RLP_ASSERT_ALWAYS(a_count_cap,
    !rst_n || state_r.item_count <= 8'(MAX_ITEMS),
    "item count above capacity")

endmodule

@@ sim/rlp_flatten_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlp_flatten_checker
// Watches both channels of the RLP stream flattener, predicts the flattened
// string bytes from every accepted raw byte and compares them, field by field,
// with the results that the block hands out, in order.
// ----------------------------------------------------------------------------

module rlp_flatten_checker
  import rlp_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = 128
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  rlp_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  rlp_out_t out_data,
  output int       fail_count,
  output int       bytes_pending,
  output int       results_checked,
  output int       error_results
);

  rlp_state_t parse_st = STATE_RESET;
  rlp_out_t   flat_bytes_due[$];
  int         fails   = 0;
  int         checked = 0;
  int         errs    = 0;

  // result of the current byte, numbered with the current item count
  function automatic rlp_out_t flat_result(logic [7:0] b, logic fin, logic empt,
                                           logic last, err_t err);
    rlp_out_t r;
    r.out_byte   = b;
    r.item_index = parse_st.item_count[6:0];
    r.item_end   = fin;
    r.empty_item = empt;
    r.seq_end    = last;
    r.error_code = err;
    return r;
  endfunction

  // one parser step; returns 1 when the byte gives a result
  function automatic bit flatten_byte(logic [7:0] b, logic last, output rlp_out_t res);
    bit has;
    has = 1'b0;
    res = '0;
    case (parse_st.phase)
      PH_HEADER: begin
        if (b <= STR_LONG_MAX && parse_st.item_count >= MAX_ITEMS) begin
          res = flat_result(8'h00, 1'b0, 1'b0, last, ERR_ITEMS);
          has = 1'b1;
          parse_st.phase = PH_DRAIN;
        end else if (b <= BYTE_SINGLE_MAX) begin
          res = flat_result(b, 1'b1, 1'b0, last, ERR_NONE);
          has = 1'b1;
          parse_st.item_count++;
        end else if (b == STR_EMPTY) begin
          res = flat_result(8'h00, 1'b1, 1'b1, last, ERR_NONE);
          has = 1'b1;
          parse_st.item_count++;
        end else if (b <= STR_SHORT_MAX) begin
          if (last) begin
            res = flat_result(8'h00, 1'b0, 1'b0, last, ERR_TRUNC);
            has = 1'b1;
            parse_st.phase = PH_DRAIN;
          end else begin
            parse_st.payload_left = 32'(b - STR_EMPTY);
            parse_st.phase = PH_PAYLOAD;
          end
        end else if (b <= STR_LONG_MAX || b > LIST_SHORT_MAX) begin
          // long string or long list: length bytes follow
          if (last) begin
            res = flat_result(8'h00, 1'b0, 1'b0, last, ERR_TRUNC);
            has = 1'b1;
            parse_st.phase = PH_DRAIN;
          end else begin
            parse_st.collecting_list_length = (b > LIST_SHORT_MAX);
            parse_st.length_bytes_left =
              4'(b - ((b > LIST_SHORT_MAX) ? LIST_SHORT_MAX : STR_SHORT_MAX));
            parse_st.payload_left = '0;
            parse_st.phase = PH_LENGTH;
          end
        end
        // short list headers are consumed silently
      end
      PH_LENGTH: begin
        if (parse_st.payload_left > LEN_SHIFT_MAX) begin
          res = flat_result(8'h00, 1'b0, 1'b0, last, ERR_LEN);
          has = 1'b1;
          parse_st.phase = PH_DRAIN;
        end else begin
          parse_st.payload_left = {parse_st.payload_left[23:0], b};
          if (parse_st.length_bytes_left != 0) parse_st.length_bytes_left--;
          if (parse_st.length_bytes_left != 0) begin
            if (last) begin
              res = flat_result(8'h00, 1'b0, 1'b0, last, ERR_TRUNC);
              has = 1'b1;
              parse_st.phase = PH_DRAIN;
            end
          end else if (parse_st.collecting_list_length) begin
            parse_st.collecting_list_length = 1'b0;
            parse_st.payload_left = '0;
            parse_st.phase = PH_HEADER;
          end else if (parse_st.payload_left == 0) begin
            res = flat_result(8'h00, 1'b1, 1'b1, last, ERR_NONE);
            has = 1'b1;
            parse_st.item_count++;
            parse_st.phase = PH_HEADER;
          end else if (last) begin
            res = flat_result(8'h00, 1'b0, 1'b0, last, ERR_TRUNC);
            has = 1'b1;
            parse_st.phase = PH_DRAIN;
          end else begin
            parse_st.phase = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        if (parse_st.payload_left <= 1) begin
          res = flat_result(b, 1'b1, 1'b0, last, ERR_NONE);
          has = 1'b1;
          parse_st.item_count++;
          parse_st.payload_left = '0;
          parse_st.phase = PH_HEADER;
        end else if (last) begin
          res = flat_result(8'h00, 1'b0, 1'b0, last, ERR_TRUNC);
          has = 1'b1;
          parse_st.phase = PH_DRAIN;
        end else begin
          res = flat_result(b, 1'b0, 1'b0, 1'b0, ERR_NONE);
          has = 1'b1;
          parse_st.payload_left--;
        end
      end
      default: ;
    endcase
    // every sequence starts from a clean parser
    if (last) parse_st = STATE_RESET;
    return has;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("checker: result %0d %s: got %0h, expected %0h", checked, what, got, want);
    fails++;
  endtask

  task automatic check_result(rlp_out_t got, rlp_out_t want);
    if (got.out_byte !== want.out_byte)
      report_mismatch("out_byte", 32'(got.out_byte), 32'(want.out_byte));
    if (got.item_index !== want.item_index)
      report_mismatch("item_index", 32'(got.item_index), 32'(want.item_index));
    if (got.item_end !== want.item_end)
      report_mismatch("item_end", 32'(got.item_end), 32'(want.item_end));
    if (got.empty_item !== want.empty_item)
      report_mismatch("empty_item", 32'(got.empty_item), 32'(want.empty_item));
    if (got.seq_end !== want.seq_end)
      report_mismatch("seq_end", 32'(got.seq_end), 32'(want.seq_end));
    if (got.error_code !== want.error_code)
      report_mismatch("error_code", 32'(got.error_code), 32'(want.error_code));
  endtask

  // predict on accepted input items, compare on accepted results
  always @(posedge clk) begin : watch
    rlp_out_t due;
    if (!rst_n) begin
      parse_st = STATE_RESET;
      flat_bytes_due.delete();
    end else begin
      if (in_valid && in_ready) begin
        if (flatten_byte(in_data.in_byte, in_data.seq_last, due)) flat_bytes_due.push_back(due);
      end
      if (out_valid && out_ready) begin
        checked++;
        if (flat_bytes_due.size() == 0) begin
          report_mismatch("arrived with none due", 32'(out_data), '0);
        end else begin
          due = flat_bytes_due.pop_front();
          if (due.error_code != ERR_NONE) errs++;
          check_result(out_data, due);
        end
      end
    end
    fail_count      <= fails;
    bytes_pending   <= flat_bytes_due.size();
    results_checked <= checked;
    error_results   <= errs;
  end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives RLP-encoded sequences into the stream flattener with random gaps and
// result stalls: a short directed set first, then mostly well-formed random
// sequences mixed with cut, noisy, oversized and overcrowded ones.
// ----------------------------------------------------------------------------

module tb;
  import rlp_pkg::*;

  localparam int unsigned MAX_ITEMS   = 128;
  localparam int          BYTE_TARGET = 1600;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          SETTLE      = 8;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  rlp_in_if  in_ch ();
  rlp_out_if out_ch ();

  int         fail_count;
  int         bytes_pending;
  int         results_checked;
  int         error_results;
  int         cycle_count = 0;
  int         bytes_sent  = 0;
  int         seqs_sent   = 0;
  int         src_run     = 0;
  int         snk_run     = 0;
  bit         src_calm;
  bit         snk_calm;
  logic [7:0] seq_q[$];

  // clock and reset
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  rlp_stream_flattener #(
    .MAX_ITEMS(MAX_ITEMS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch)
  );

  rlp_flatten_checker #(
    .MAX_ITEMS(MAX_ITEMS)
  ) chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_data        (in_ch.data),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_data       (out_ch.data),
    .fail_count     (fail_count),
    .bytes_pending  (bytes_pending),
    .results_checked(results_checked),
    .error_results  (error_results)
  );

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb: failure");
      $finish;
    end
  end

  // wait per item, with calm stretches that have no idling at all
  function automatic int idle_cycles(inout int run_left, inout bit calm);
    if (run_left == 0) begin
      run_left = $urandom_range(10, 60);
      calm = ($urandom_range(0, 3) == 0);
    end
    run_left--;
    return calm ? 0 : $urandom_range(0, 18);
  endfunction

  // result side: random stalls before each item
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = idle_cycles(snk_run, snk_calm);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = idle_cycles(src_run, src_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= '{in_byte: b, seq_last: last};
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_seq();
    foreach (seq_q[i]) send_byte(seq_q[i], i == seq_q.size() - 1);
    seq_q.delete();
    seqs_sent++;
  endtask

  // hold the sender until every predicted byte has come out
  task automatic drain_pause();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (bytes_pending != 0) @(posedge clk);
  endtask

  // string item in short or long form, long form sometimes with leading zeros
  task automatic put_string(input int len);
    int nlen;
    int lead;
    if (len == 1 && $urandom_range(0, 1) == 1) begin
      seq_q.push_back(8'($urandom_range(0, BYTE_SINGLE_MAX)));
      return;
    end
    if (len <= STR_SHORT_MAX - STR_EMPTY && $urandom_range(0, 2) != 0) begin
      seq_q.push_back(STR_EMPTY + 8'(len));
    end else begin
      nlen = (len > 255) ? 2 : 1;
      lead = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8 - nlen) : 0;
      seq_q.push_back(STR_SHORT_MAX + 8'(nlen + lead));
      repeat (lead) seq_q.push_back(8'h00);
      for (int i = nlen - 1; i >= 0; i--) seq_q.push_back(8'(len >> (8 * i)));
    end
    repeat (len) seq_q.push_back(8'($urandom));
  endtask

  // list header, short or long; its length is never checked
  task automatic put_list_header();
    int n;
    int k;
    if ($urandom_range(0, 1) == 0) begin
      seq_q.push_back(8'($urandom_range(STR_LONG_MAX + 1, LIST_SHORT_MAX)));
    end else begin
      n = $urandom_range(1, 8);
      k = $urandom_range(1, (n < 4) ? n : 4);
      seq_q.push_back(LIST_SHORT_MAX + 8'(n));
      repeat (n - k) seq_q.push_back(8'h00);
      repeat (k) seq_q.push_back(8'($urandom));
    end
  endtask

  // stimulus
  initial begin
    int pick;
    int n;
    int r;
    int keep;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    do @(posedge clk); while (!rst_n);

    // single bytes at both ends, then an empty string closing the sequence
    seq_q = '{8'h00, 8'h7f, 8'h80};
    send_seq();
    // short list, two-byte string, long-form empty string
    seq_q = '{8'hc1, 8'h82, 8'hff, 8'h01, 8'hb8, 8'h00};
    send_seq();
    // sequence ends inside a payload
    seq_q = '{8'h83, 8'h01};
    send_seq();
    // long list header, then a single byte
    seq_q = '{8'hf8, 8'h05, 8'h00};
    send_seq();
    // length past 32 bits on the closing byte
    seq_q = '{8'hbc, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05};
    send_seq();
    // length past 32 bits, the rest of the sequence dropped
    seq_q = '{8'hff, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'haa};
    send_seq();
    // long list header cut off, then a short list header alone
    seq_q = '{8'hff};
    send_seq();
    seq_q = '{8'hf7};
    send_seq();
    drain_pause();

    while (bytes_sent < BYTE_TARGET) begin
      pick = $urandom_range(0, 99);
      if (seqs_sent == 12 || pick == 0) begin
        // crowd of one-byte items around the item limit
        n = (seqs_sent == 12) ? MAX_ITEMS + 2 : $urandom_range(MAX_ITEMS - 2, MAX_ITEMS + 2);
        repeat (n) seq_q.push_back(($urandom_range(0, 3) == 0) ?
                                   STR_EMPTY : 8'($urandom_range(0, BYTE_SINGLE_MAX)));
      end else if (pick < 8) begin
        // raw noise
        repeat ($urandom_range(1, 12)) seq_q.push_back(8'($urandom));
      end else if (pick < 13) begin
        // long form whose length runs past 32 bits
        n = $urandom_range(5, 8);
        seq_q.push_back((($urandom_range(0, 1) == 0) ? STR_SHORT_MAX : LIST_SHORT_MAX) + 8'(n));
        seq_q.push_back(8'($urandom_range(1, 255)));
        repeat (n - 1 + $urandom_range(0, 3)) seq_q.push_back(8'($urandom));
      end else begin
        // well-formed items and list headers, some cut short
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(0, 2) == 0) begin
            put_list_header();
          end else begin
            r = $urandom_range(0, 39);
            if (r < 20) put_string($urandom_range(0, 3));
            else if (r < 36) put_string($urandom_range(4, 24));
            else if (r < 39) put_string($urandom_range(25, 70));
            else put_string($urandom_range(250, 300));
          end
        end
        if (pick < 25 && seq_q.size() > 1) begin
          keep = $urandom_range(1, seq_q.size() - 1);
          while (seq_q.size() > keep) void'(seq_q.pop_back());
        end
      end
      send_seq();
      if (seqs_sent % 40 == 0) drain_pause();
    end

    drain_pause();
    repeat (SETTLE) @(posedge clk);
    $display("summary: %0d bytes in %0d sequences, %0d results checked, %0d carried an error",
             bytes_sent, seqs_sent, results_checked, error_results);
    $display("summary: strings short and long, list headers, cut sequences, item overflow");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/rlp_pkg.sv
rtl/core/rlp_if.sv
rtl/core/rlp_step.sv
rtl/core/rlp_stream_flattener.sv
sim/rlp_flatten_checker.sv
sim/tb.sv
